/* src/two_level_direct_mapped_cache_core_defines.svh */
// Assertion macros for the two-level cache core.
`ifndef TWO_LEVEL_DIRECT_MAPPED_CACHE_CORE_DEFINES_SVH
`define TWO_LEVEL_DIRECT_MAPPED_CACHE_CORE_DEFINES_SVH
`ifndef SYNTH
`define TLDMC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define TLDMC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) ante |=> cons) \
      else $error("%m: sequencing check failed");
`else
`define TLDMC_ASSERT(label, prop, msg)
`define TLDMC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* src/tldmc_pkg.sv */
`timescale 1ns / 1ps
package tldmc_pkg;
   localparam int BLOCK_BYTES = 64;
   localparam int WORD_BYTES  = 4;
   localparam int L1_LINES    = 256;
   localparam int L2_LINES    = 512;
   localparam int MEM_BYTES   = 65536;

   localparam int WPB         = BLOCK_BYTES / WORD_BYTES;
   localparam int MEM_WORDS   = MEM_BYTES / WORD_BYTES;

   localparam int WORD_BITS   = 32;
   localparam int ADDR_BITS   = 16;
   localparam int COST_BITS   = 19;
   localparam int CFG_BITS    = 16;
   localparam int CSR_IDX_BITS = 3;
   localparam int BOFF_BITS   = $clog2(WORD_BYTES);
   localparam int WOFF_BITS   = $clog2(WPB);
   localparam int OFF_BITS    = BOFF_BITS + WOFF_BITS;
   localparam int BLK_BITS    = ADDR_BITS - OFF_BITS;
   localparam int L1_IDX_BITS = $clog2(L1_LINES);
   localparam int L1_TAG_BITS = BLK_BITS - L1_IDX_BITS;
   localparam int L2_IDX_BITS = $clog2(L2_LINES);
   localparam int L2_TAG_BITS = BLK_BITS - L2_IDX_BITS;
   localparam int MEM_ADDR_BITS = $clog2(MEM_WORDS);
   localparam int CNT_BITS    = WOFF_BITS + 1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_L1_READ  = 3'd0,
      CSR_L1_WRITE = 3'd1,
      CSR_L2_READ  = 3'd2,
      CSR_L2_WRITE = 3'd3,
      CSR_MEM_READ = 3'd4,
      CSR_MEM_WRITE = 3'd5
   } csr_index_type;

   localparam int CSR_COUNT = 6;

   localparam logic [CFG_BITS-1:0] L1_READ_RESET   = 16'd1;
   localparam logic [CFG_BITS-1:0] L1_WRITE_RESET  = 16'd1;
   localparam logic [CFG_BITS-1:0] L2_READ_RESET   = 16'd10;
   localparam logic [CFG_BITS-1:0] L2_WRITE_RESET  = 16'd10;
   localparam logic [CFG_BITS-1:0] MEM_READ_RESET  = 16'd100;
   localparam logic [CFG_BITS-1:0] MEM_WRITE_RESET = 16'd100;

   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   typedef struct packed {
      logic                   valid;
      logic                   dirty;
      logic [L1_TAG_BITS-1:0] tag;
   } l1_meta_type;

   typedef struct packed {
      logic                   valid;
      logic                   dirty;
      logic [L2_TAG_BITS-1:0] tag;
   } l2_meta_type;

   typedef enum logic [11:0] {
      ST_CLEAR     = 12'b0000_0000_0001,
      ST_IDLE      = 12'b0000_0000_0010,
      ST_LOOK      = 12'b0000_0000_0100,
      ST_CHECK     = 12'b0000_0000_1000,
      ST_F_META    = 12'b0000_0001_0000,
      ST_F_CHK     = 12'b0000_0010_0000,
      ST_WB_L2     = 12'b0000_0100_0000,
      ST_FILL_L2   = 12'b0000_1000_0000,
      ST_L2_TO_TMP = 12'b0001_0000_0000,
      ST_L1_TO_L2  = 12'b0010_0000_0000,
      ST_TMP_TO_L1 = 12'b0100_0000_0000,
      ST_RESP      = 12'b1000_0000_0000
   } state_type;
endpackage

/* src/tldmc_req_if.sv */
`timescale 1ns / 1ps
interface tldmc_req_if import tldmc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 func;
   logic [ADDR_BITS-1:0] address;
   logic [WORD_BITS-1:0] write_data;

   modport source (output valid, func, address, write_data, input ready);
   modport sink (input valid, func, address, write_data, output ready);
endinterface

/* src/tldmc_rsp_if.sv */
`timescale 1ns / 1ps
interface tldmc_rsp_if import tldmc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] read_data;
   logic                 l1_hit;
   logic                 l2_hit;
   logic [COST_BITS-1:0] access_cost;
   logic                 addr_error;

   modport source (output valid, read_data, l1_hit, l2_hit, access_cost, addr_error,
                   input ready);
   modport sink (input valid, read_data, l1_hit, l2_hit, access_cost, addr_error,
                 output ready);
endinterface

/* src/two_level_direct_mapped_cache_core.sv */
`timescale 1ns / 1ps
// Word read/write through a direct-mapped write-back L1 (256 lines), a direct-mapped
// write-back L2 (512 lines) and a 16384-word backing memory, all in synchronous RAMs
// with one read and one write port each. After reset the block runs a clearing pass that
// zeroes the backing memory and all valid and dirty bits; it accepts no transaction meanwhile.
// One transaction is handled at a time. Misses move blocks one word per cycle through the
// RAM ports; the longest misses are those in which both a dirty L1 victim and dirty L2
// victims must be written back. Misaligned addresses are answered with addr_error and
// change nothing.
`include "two_level_direct_mapped_cache_core_defines.svh"
module two_level_direct_mapped_cache_core import tldmc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   tldmc_req_if.sink               req_chan,
   tldmc_rsp_if.source             rsp_chan,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_wdata
);

   logic [WORD_BITS-1:0]   l1_data_mem [L1_LINES*WPB];
   logic [WORD_BITS-1:0]   l2_data_mem [L2_LINES*WPB];
   logic [WORD_BITS-1:0]   back_mem    [MEM_WORDS];
   l1_meta_type            l1_meta_mem [L1_LINES];
   l2_meta_type            l2_meta_mem [L2_LINES];

   logic [CFG_BITS-1:0]    cfg_ff [CSR_COUNT];

   state_type              state_ff, state_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [MEM_ADDR_BITS-1:0] clr_ff, clr_in;
   logic                   func_ff, func_in;
   logic [ADDR_BITS-1:0]   addr_ff, addr_in;
   logic [WORD_BITS-1:0]   wdata_ff, wdata_in;
   logic [BLK_BITS-1:0]    fa_ff, fa_in;
   logic                   phase_ff, phase_in;
   logic                   missed_ff, missed_in;
   logic                   l2h_ff, l2h_in;
   l1_meta_type            vmeta_ff, vmeta_in;
   logic [L2_TAG_BITS-1:0] wbtag_ff, wbtag_in;
   logic [COST_BITS-1:0]   cost_ff, cost_in;
   logic [WORD_BITS-1:0]   rsp_rdata_ff, rsp_rdata_in;
   logic                   rsp_l1_hit_ff, rsp_l1_hit_in;
   logic                   rsp_err_ff, rsp_err_in;
   logic [WORD_BITS-1:0]   tmp_ff [WPB];

   logic [WORD_BITS-1:0]   l1d_rdata_ff, l2d_rdata_ff, back_rdata_ff;
   l1_meta_type            l1m_rdata_ff;
   l2_meta_type            l2m_rdata_ff;

   logic                   l1d_we, l2d_we, back_we, l1m_we, l2m_we, tmp_we;
   logic [L1_IDX_BITS+WOFF_BITS-1:0] l1d_raddr, l1d_waddr;
   logic [L2_IDX_BITS+WOFF_BITS-1:0] l2d_raddr, l2d_waddr;
   logic [MEM_ADDR_BITS-1:0] back_raddr, back_waddr;
   logic [L1_IDX_BITS-1:0] l1m_waddr;
   logic [L2_IDX_BITS-1:0] l2m_waddr;
   logic [WORD_BITS-1:0]   l1d_wdata, l2d_wdata, back_wdata;
   l1_meta_type            l1m_wdata;
   l2_meta_type            l2m_wdata;

   logic [BLK_BITS-1:0]    req_blk;
   logic [L1_IDX_BITS-1:0] l1_idx;
   logic [L1_TAG_BITS-1:0] l1_tag;
   logic [WOFF_BITS-1:0]   woff;
   logic [L2_IDX_BITS-1:0] fa_idx;
   logic [L2_TAG_BITS-1:0] fa_tag;
   logic [WOFF_BITS-1:0]   cnt_lo, cnt_prev;
   logic                   cnt_done;
   logic                   l1_hit_now, l2_hit_now;

   assign req_blk  = addr_ff[ADDR_BITS-1:OFF_BITS];
   assign l1_idx   = req_blk[L1_IDX_BITS-1:0];
   assign l1_tag   = req_blk[BLK_BITS-1:L1_IDX_BITS];
   assign woff     = addr_ff[OFF_BITS-1:BOFF_BITS];
   assign fa_idx   = fa_ff[L2_IDX_BITS-1:0];
   assign fa_tag   = fa_ff[BLK_BITS-1:L2_IDX_BITS];
   assign cnt_lo   = cnt_ff[WOFF_BITS-1:0];
   assign cnt_prev = cnt_lo - WOFF_BITS'(1);
   assign cnt_done = cnt_ff[CNT_BITS-1];
   assign l1_hit_now = l1m_rdata_ff.valid && (l1m_rdata_ff.tag == l1_tag);
   assign l2_hit_now = l2m_rdata_ff.valid && (l2m_rdata_ff.tag == fa_tag);

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = (state_ff == ST_RESP);
   assign rsp_chan.read_data   = rsp_rdata_ff;
   assign rsp_chan.l1_hit      = rsp_l1_hit_ff;
   assign rsp_chan.l2_hit      = l2h_ff;
   assign rsp_chan.access_cost = cost_ff;
   assign rsp_chan.addr_error  = rsp_err_ff;

   assign l1d_raddr  = {l1_idx, (state_ff == ST_LOOK) ? woff : cnt_lo};
   assign l2d_raddr  = {fa_idx, cnt_lo};
   assign back_raddr = {fa_ff, cnt_lo};

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      clr_in        = clr_ff;
      func_in       = func_ff;
      addr_in       = addr_ff;
      wdata_in      = wdata_ff;
      fa_in         = fa_ff;
      phase_in      = phase_ff;
      missed_in     = missed_ff;
      l2h_in        = l2h_ff;
      vmeta_in      = vmeta_ff;
      wbtag_in      = wbtag_ff;
      cost_in       = cost_ff;
      rsp_rdata_in  = rsp_rdata_ff;
      rsp_l1_hit_in = rsp_l1_hit_ff;
      rsp_err_in    = rsp_err_ff;
      l1d_we = 1'b0;
      l2d_we = 1'b0;
      back_we = 1'b0;
      l1m_we = 1'b0;
      l2m_we = 1'b0;
      tmp_we = 1'b0;
      l1d_waddr  = {l1_idx, cnt_lo};
      l1d_wdata  = tmp_ff[cnt_lo];
      l2d_waddr  = {fa_idx, cnt_prev};
      l2d_wdata  = back_rdata_ff;
      back_waddr = {wbtag_ff, fa_idx, cnt_prev};
      back_wdata = l2d_rdata_ff;
      l1m_waddr  = l1_idx;
      l1m_wdata  = '{valid: 1'b1, dirty: 1'b0, tag: l1_tag};
      l2m_waddr  = fa_idx;
      l2m_wdata  = '{valid: 1'b1, dirty: 1'b0, tag: fa_tag};
      unique case (state_ff)
         ST_CLEAR: begin
            back_we    = 1'b1;
            back_waddr = clr_ff;
            back_wdata = '0;
            l1m_we     = 1'b1;
            l1m_waddr  = clr_ff[L1_IDX_BITS-1:0];
            l1m_wdata  = '0;
            l2m_we     = 1'b1;
            l2m_waddr  = clr_ff[L2_IDX_BITS-1:0];
            l2m_wdata  = '0;
            clr_in     = clr_ff + MEM_ADDR_BITS'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               func_in       = req_chan.func;
               addr_in       = req_chan.address;
               wdata_in      = req_chan.write_data;
               missed_in     = 1'b0;
               l2h_in        = 1'b0;
               cost_in       = '0;
               rsp_rdata_in  = '0;
               rsp_l1_hit_in = 1'b0;
               if (|req_chan.address[BOFF_BITS-1:0]) begin
                  rsp_err_in = 1'b1;
                  state_in   = ST_RESP;
               end else begin
                  rsp_err_in = 1'b0;
                  state_in   = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (l1_hit_now) begin
               rsp_l1_hit_in = !missed_ff;
               if (func_ff == FUNC_READ) begin
                  rsp_rdata_in = l1d_rdata_ff;
                  cost_in = cost_ff + COST_BITS'(cfg_ff[CSR_L1_READ]);
               end else begin
                  l1d_we    = 1'b1;
                  l1d_waddr = {l1_idx, woff};
                  l1d_wdata = wdata_ff;
                  l1m_we    = 1'b1;
                  l1m_wdata = '{valid: 1'b1, dirty: 1'b1, tag: l1_tag};
                  cost_in = cost_ff + COST_BITS'(cfg_ff[CSR_L1_WRITE]);
               end
               state_in = ST_RESP;
            end else begin
               vmeta_in = l1m_rdata_ff;
               fa_in    = req_blk;
               phase_in = 1'b0;
               state_in = ST_F_META;
            end
         end
         ST_F_META: begin
            state_in = ST_F_CHK;
         end
         ST_F_CHK: begin
            cnt_in = '0;
            if (l2_hit_now) begin
               if (!phase_ff) begin
                  l2h_in = 1'b1;
               end
               state_in = phase_ff ? ST_L1_TO_L2 : ST_L2_TO_TMP;
            end else if (l2m_rdata_ff.valid && l2m_rdata_ff.dirty) begin
               cost_in  = cost_ff + COST_BITS'(cfg_ff[CSR_MEM_READ])
                          + COST_BITS'(cfg_ff[CSR_MEM_WRITE]);
               wbtag_in = l2m_rdata_ff.tag;
               state_in = ST_WB_L2;
            end else begin
               cost_in  = cost_ff + COST_BITS'(cfg_ff[CSR_MEM_READ]);
               state_in = ST_FILL_L2;
            end
         end
         ST_WB_L2: begin
            cnt_in  = cnt_ff + CNT_BITS'(1);
            back_we = (cnt_ff != '0);
            if (cnt_done) begin
               cnt_in   = '0;
               state_in = ST_FILL_L2;
            end
         end
         ST_FILL_L2: begin
            cnt_in = cnt_ff + CNT_BITS'(1);
            l2d_we = (cnt_ff != '0);
            if (cnt_done) begin
               cnt_in   = '0;
               l2m_we   = 1'b1;
               state_in = phase_ff ? ST_L1_TO_L2 : ST_L2_TO_TMP;
            end
         end
         ST_L2_TO_TMP: begin
            cnt_in = cnt_ff + CNT_BITS'(1);
            tmp_we = (cnt_ff != '0);
            if (cnt_done) begin
               cnt_in  = '0;
               cost_in = cost_ff + COST_BITS'(cfg_ff[CSR_L2_READ]);
               if (vmeta_ff.valid && vmeta_ff.dirty) begin
                  fa_in    = {vmeta_ff.tag, l1_idx};
                  phase_in = 1'b1;
                  state_in = ST_F_META;
               end else begin
                  state_in = ST_TMP_TO_L1;
               end
            end
         end
         ST_L1_TO_L2: begin
            cnt_in    = cnt_ff + CNT_BITS'(1);
            l2d_we    = (cnt_ff != '0);
            l2d_wdata = l1d_rdata_ff;
            if (cnt_done) begin
               cnt_in    = '0;
               l2m_we    = 1'b1;
               l2m_wdata = '{valid: 1'b1, dirty: 1'b1, tag: fa_tag};
               cost_in   = cost_ff + COST_BITS'(cfg_ff[CSR_L2_WRITE]);
               state_in  = ST_TMP_TO_L1;
            end
         end
         ST_TMP_TO_L1: begin
            cnt_in = cnt_ff + CNT_BITS'(1);
            l1d_we = 1'b1;
            if (&cnt_lo) begin
               cnt_in    = '0;
               l1m_we    = 1'b1;
               missed_in = 1'b1;
               state_in  = ST_LOOK;
            end
         end
         ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         cnt_ff    <= '0;
         clr_ff    <= '0;
         phase_ff  <= 1'b0;
         missed_ff <= 1'b0;
         cfg_ff[CSR_L1_READ]   <= L1_READ_RESET;
         cfg_ff[CSR_L1_WRITE]  <= L1_WRITE_RESET;
         cfg_ff[CSR_L2_READ]   <= L2_READ_RESET;
         cfg_ff[CSR_L2_WRITE]  <= L2_WRITE_RESET;
         cfg_ff[CSR_MEM_READ]  <= MEM_READ_RESET;
         cfg_ff[CSR_MEM_WRITE] <= MEM_WRITE_RESET;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         clr_ff    <= clr_in;
         phase_ff  <= phase_in;
         missed_ff <= missed_in;
         if (csr_wr_en && (csr_index < CSR_IDX_BITS'(CSR_COUNT))) begin
            cfg_ff[csr_index] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      addr_ff       <= addr_in;
      wdata_ff      <= wdata_in;
      fa_ff         <= fa_in;
      l2h_ff        <= l2h_in;
      vmeta_ff      <= vmeta_in;
      wbtag_ff      <= wbtag_in;
      cost_ff       <= cost_in;
      rsp_rdata_ff  <= rsp_rdata_in;
      rsp_l1_hit_ff <= rsp_l1_hit_in;
      rsp_err_ff    <= rsp_err_in;
      if (tmp_we) begin
         tmp_ff[cnt_prev] <= l2d_rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (l1d_we) begin
         l1_data_mem[l1d_waddr] <= l1d_wdata;
      end
      l1d_rdata_ff <= l1_data_mem[l1d_raddr];
   end

   always_ff @(posedge clock) begin
      if (l2d_we) begin
         l2_data_mem[l2d_waddr] <= l2d_wdata;
      end
      l2d_rdata_ff <= l2_data_mem[l2d_raddr];
   end

   always_ff @(posedge clock) begin
      if (back_we) begin
         back_mem[back_waddr] <= back_wdata;
      end
      back_rdata_ff <= back_mem[back_raddr];
   end

   always_ff @(posedge clock) begin
      if (l1m_we) begin
         l1_meta_mem[l1m_waddr] <= l1m_wdata;
      end
      l1m_rdata_ff <= l1_meta_mem[l1_idx];
   end

   always_ff @(posedge clock) begin
      if (l2m_we) begin
         l2_meta_mem[l2m_waddr] <= l2m_wdata;
      end
      l2m_rdata_ff <= l2_meta_mem[fa_idx];
   end

   `TLDMC_ASSERT(a_refill_hits, (state_ff == ST_CHECK && missed_ff) |-> l1_hit_now,
      "L1 lookup missed right after a line fill")
   `TLDMC_ASSERT(a_error_quiet, (rsp_chan.valid && rsp_chan.addr_error) |-> (rsp_chan.access_cost == '0 && !rsp_chan.l1_hit && !rsp_chan.l2_hit && rsp_chan.read_data == '0),
      "Address error transaction carries nonzero fields")
   `TLDMC_ASSERT(a_hit_flags, rsp_chan.valid |-> !(rsp_chan.l1_hit && rsp_chan.l2_hit),
      "Both L1 and L2 hit flags set")
   `TLDMC_ASSERT_NEXT(a_fill_return, (state_ff == ST_FILL_L2 && cnt_done),
      (state_ff == ST_L2_TO_TMP || state_ff == ST_L1_TO_L2))

endmodule
